[rtl/core/assert_macros.svh]
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CHRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHRS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/chrs_pkg.sv]
// types and constants of the hash ring selector
package chrs_pkg;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_KEY    = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  service;
        logic [7:0]  instance_req;
        logic [31:0] node_hash;
        logic [7:0]  key_byte;
        logic        key_last;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] chosen_instance;
    } t_out;

    typedef struct packed {
        logic [31:0] hash;
        logic [7:0]  inst;
        logic [3:0]  svc;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_CHK, S_INS_RD, S_INS_CMP, S_REM_RD, S_REM_CMP,
        S_HASH, S_LK_RD, S_LK_CMP, S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    clear;
        logic    hash_mul;
        logic    hash_reset;
        logic    ins_init;
        logic    rd;
        logic    rd_prev;
        logic    ins_shift;
        logic    ins_place;
        logic    rem_step;
        logic    rem_done;
        logic    lk_step;
        logic    set_res;
        logic    res_lookup;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic idx_end;
        logic ins_gt;
        logic found;
        logic out_busy;
    } t_sts;
endpackage

[rtl/core/chrs_ctrl.sv]
// controller state machine of the hash ring selector
module chrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_kind,
    input  logic          i_last,
    input  chrs_pkg::t_sts i_sts,
    output logic          o_stall,
    output chrs_pkg::t_cmd o_cmd
);
    import chrs_pkg::*;

    t_state r_state;
    t_state n_state;
    t_kind  w_kind;
    logic   w_acc;

    assign w_kind = t_kind'(i_kind);
    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_kind)
                        KIND_INSERT: n_state = S_INS_CHK;
                        KIND_REMOVE: n_state = S_REM_RD;
                        KIND_KEY:    n_state = S_HASH;
                        KIND_CLEAR:  n_state = S_DONE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_CHK: n_state = i_sts.full ? S_DONE : S_INS_RD;
            S_INS_RD:  n_state = i_sts.idx_zero ? S_DONE : S_INS_CMP;
            S_INS_CMP: n_state = i_sts.ins_gt ? S_INS_RD : S_DONE;
            S_REM_RD:  n_state = i_sts.idx_end ? S_DONE : S_REM_CMP;
            S_REM_CMP: n_state = S_REM_RD;
            S_HASH:    n_state = i_last ? S_LK_RD : S_IDLE;
            S_LK_RD:   n_state = (i_sts.idx_end || i_sts.found) ? S_DONE : S_LK_CMP;
            S_LK_CMP:  n_state = S_LK_RD;
            S_DONE:    n_state = i_sts.out_busy ? S_DONE : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    if (w_kind == KIND_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        o_cmd.set_res = 1'b1;
                    end
                end
            end
            S_INS_CHK: begin
                if (i_sts.full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_code = ST_FULL;
                end else begin
                    o_cmd.ins_init = 1'b1;
                end
            end
            S_INS_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.ins_place = 1'b1;
                    o_cmd.set_res = 1'b1;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                end
            end
            S_INS_CMP: begin
                if (i_sts.ins_gt) begin
                    o_cmd.ins_shift = 1'b1;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    o_cmd.set_res = 1'b1;
                end
            end
            S_REM_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.rem_done = 1'b1;
                    o_cmd.set_res = 1'b1;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_REM_CMP: o_cmd.rem_step = 1'b1;
            S_HASH:    o_cmd.hash_mul = 1'b1;
            S_LK_RD: begin
                if (i_sts.idx_end || i_sts.found) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_lookup = 1'b1;
                    o_cmd.hash_reset = 1'b1;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_LK_CMP: o_cmd.lk_step = 1'b1;
            S_DONE:   o_cmd.out_load = !i_sts.out_busy;
            default:  o_cmd = '0;
        endcase
    end
endmodule

[rtl/core/chrs_dp.sv]
// datapath of the hash ring selector: ring memory, hash, scan pointers, result
module chrs_dp #(
    parameter int RING_SIZE = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chrs_pkg::t_in  i_item,
    input  chrs_pkg::t_cmd i_cmd,
    input  logic           i_stall,
    output chrs_pkg::t_sts o_sts,
    output logic           o_valid,
    output chrs_pkg::t_out o_item,
    output logic           o_last
);
    import chrs_pkg::*;

    localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int CW = $clog2(RING_SIZE + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(RING_SIZE);

    t_entry        mem [RING_SIZE];
    t_entry        r_rd;
    logic [CW-1:0] r_cnt, r_idx, r_wr;
    logic [31:0]   r_hash, r_x;
    logic [3:0]    r_svc;
    logic [7:0]    r_inst;
    logic [31:0]   r_nh;
    logic          r_last;
    logic          r_found, r_have_first;
    logic [7:0]    r_first, r_res;
    logic [1:0]    r_pst;
    logic [7:0]    r_pinst;
    logic          r_out_valid;
    t_out          r_out;
    logic [CW-1:0] w_prev;
    logic          w_match;
    logic          w_we;
    logic [AW-1:0] w_wa;
    t_entry        w_wd;
    t_entry        w_new;

    assign w_prev = r_idx - CW'(1);
    assign w_match = (r_rd.svc == r_svc) && (r_rd.inst == r_inst);
    assign w_new = '{hash: r_nh, inst: r_inst, svc: r_svc};

    assign o_sts.full     = (r_cnt == CNT_MAX);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_end  = (r_idx == r_cnt);
    assign o_sts.ins_gt   = (r_rd.hash > r_nh);
    assign o_sts.found    = r_found;
    assign o_sts.out_busy = r_out_valid && i_stall;
    assign o_valid = r_out_valid;
    assign o_item = r_out;
    assign o_last = r_last;

    // one write port: shift up, place new node, or compact on remove
    always_comb begin
        w_we = 1'b0;
        w_wa = r_idx[AW-1:0];
        w_wd = r_rd;
        if (i_cmd.ins_shift) begin
            w_we = 1'b1;
        end else if (i_cmd.ins_place) begin
            w_we = 1'b1;
            w_wd = w_new;
        end else if (i_cmd.rem_step && !w_match) begin
            w_we = 1'b1;
            w_wa = r_wr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[i_cmd.rd_prev ? w_prev[AW-1:0] : r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_svc <= i_item.service;
            r_inst <= i_item.instance_req;
            r_nh <= i_item.node_hash;
            r_last <= i_item.key_last;
            r_x <= r_hash ^ {24'd0, i_item.key_byte};
        end
        if (i_cmd.lk_step && (r_rd.svc == r_svc)) begin
            if (!r_have_first) begin
                r_first <= r_rd.inst;
            end
            if (!r_found && (r_rd.hash >= r_hash)) begin
                r_res <= r_rd.inst;
            end
        end
        if (i_cmd.set_res) begin
            if (i_cmd.res_lookup) begin
                priority if (r_found) begin
                    r_pst <= ST_OK;
                    r_pinst <= r_res;
                end else if (r_have_first) begin
                    r_pst <= ST_OK;
                    r_pinst <= r_first;
                end else begin
                    r_pst <= ST_EMPTY;
                    r_pinst <= 8'd0;
                end
            end else begin
                r_pst <= i_cmd.res_code;
                r_pinst <= 8'd0;
            end
        end
        if (i_cmd.out_load) begin
            r_out.status <= r_pst;
            r_out.chosen_instance <= r_pinst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
            r_wr <= '0;
            r_hash <= FNV_BASIS;
            r_found <= 1'b0;
            r_have_first <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_idx <= '0;
                r_wr <= '0;
                r_found <= 1'b0;
                r_have_first <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end
            if (i_cmd.hash_mul) begin
                r_hash <= r_x * FNV_PRIME;
            end else if (i_cmd.hash_reset) begin
                r_hash <= FNV_BASIS;
            end
            if (i_cmd.ins_init) begin
                r_idx <= r_cnt;
            end
            if (i_cmd.ins_shift) begin
                r_idx <= w_prev;
            end
            if (i_cmd.ins_place) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.rem_step) begin
                r_idx <= r_idx + CW'(1);
                if (!w_match) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            if (i_cmd.rem_done) begin
                r_cnt <= r_wr;
            end
            if (i_cmd.lk_step) begin
                r_idx <= r_idx + CW'(1);
                if (r_rd.svc == r_svc) begin
                    r_have_first <= 1'b1;
                    if (r_rd.hash >= r_hash) begin
                        r_found <= 1'b1;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

[rtl/core/consistent_hash_ring_select.sv]
// Consistent-hash ring selector. One single-port ring memory of RING_SIZE virtual
// nodes is kept sorted by hash; each memory entry is read, then compared or moved,
// in separate states. Insert checks for a full table first (a full table answers
// FULL without a scan), then walks down past the k nodes with a larger hash,
// moving each one up, and places the new node below them; remove reads all N
// stored nodes and compacts out the matching ones; a key byte takes one 32-bit
// multiply, and the last byte adds a lookup scan over the entries read up to the
// first hit, at most all N. Clear empties the table when it is taken. Every item
// is taken in the idle state, and the final busy state waits while an older
// result is still stalled. One item is worked at a time; the result sits in an
// output register so the next item is taken while it waits. No clearing pass
// after reset.
module consistent_hash_ring_select #(
    parameter int RING_SIZE = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  chrs_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output chrs_pkg::t_out o_item
);
    import chrs_pkg::*;
    `include "assert_macros.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_last;
    logic w_acc;

    assign w_acc = i_valid && !o_stall;

    chrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_item.kind),
        .i_last  (w_last),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    chrs_dp #(.RING_SIZE(RING_SIZE)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .i_stall (i_stall),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_item  (o_item),
        .o_last  (w_last)
    );

    `CHRS_ASSERT_NXT(a_busy_after_item, i_clk, i_rst_n, w_acc, o_stall)
    `CHRS_ASSERT_IMP(a_result_after_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))
    `CHRS_ASSERT_IMP(a_one_write_op, i_clk, i_rst_n, 1'b1,
        $onehot0({w_cmd.ins_shift, w_cmd.ins_place, w_cmd.rem_step, w_cmd.lk_step}))
endmodule
